// ===== design/wsm_pkg.sv =====
// shared types and constants for the weighted five-point stencil block
// no dependencies; every other file of the block refers to it by scoped names
`default_nettype none

package wsm_pkg;

    localparam int CFG_W     = 11;    // width of each configuration register
    localparam int VAL_W     = 16;    // Q8.8 pixel value
    localparam int WGT_W     = 16;    // Q4.12 weight
    localparam int DIAG_W    = 19;    // sum of five weights
    localparam int PROD_W    = 40;    // Q.20 result
    localparam int MIN_DIM   = 2;     // smallest usable line length and line count
    localparam int CFG_LEN_RESET = 1024;
    localparam int CFG_CNT_RESET = 1024;

    // result queue sizing; credits cover the arithmetic pipeline plus slack
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;
    localparam int CREDIT_W   = 4;

    // command codes carried in tuser
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // configuration register indexes
    localparam logic REG_LINE_LENGTH = 1'b0;
    localparam logic REG_LINE_COUNT  = 1'b1;

    // one stored pixel, value in the lowest bits
    typedef struct packed {
        logic [WGT_W-1:0] sy;
        logic [WGT_W-1:0] sx;
        logic [WGT_W-1:0] w;
        logic [VAL_W-1:0] v;
    } pixel_t;

    // per-transaction control handed from the sequencer to the line store
    typedef struct packed {
        logic produce;
        logic prev_ok;
        logic next_ok;
        logic up_ok;
        logic frame_end;
    } req_t;

    // multiplier operands, already masked at frame edges
    typedef struct packed {
        logic [DIAG_W-1:0]       diag;
        logic signed [VAL_W-1:0] cv;
        logic [WGT_W-1:0]        wp;
        logic signed [VAL_W-1:0] pv;
        logic [WGT_W-1:0]        wn;
        logic signed [VAL_W-1:0] nv;
        logic [WGT_W-1:0]        wu;
        logic signed [VAL_W-1:0] uv;
        logic [WGT_W-1:0]        wd;
        logic signed [VAL_W-1:0] dv;
        logic                    frame_end;
    } op_t;

    typedef struct packed {
        logic signed [PROD_W-1:0] product;
        logic                     frame_end;
    } res_t;

endpackage

`default_nettype wire

// ===== design/wsm_line_store.sv =====
// line buffers of the stencil: newest packed line and older line of values
// read at transaction time, written back in the next cycle; uses wsm_pkg
`default_nettype none

module wsm_line_store #(
    parameter int DEPTH = 1024,
    localparam int XW = $clog2(DEPTH)
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            req_valid,
    input  wire logic [XW-1:0]   req_x,
    input  wsm_pkg::req_t        req,
    input  wsm_pkg::pixel_t      req_pixel,
    output logic                 op_valid,
    output wsm_pkg::op_t         op
);

    wsm_pkg::pixel_t prev_mem [DEPTH];
    logic [wsm_pkg::VAL_W-1:0] older_mem [DEPTH];

    logic [XW-1:0] req_x_next;

    logic            s1_valid_reg;
    logic [XW-1:0]   s1_x_reg;
    wsm_pkg::req_t   s1_req_reg;
    wsm_pkg::pixel_t s1_pixel_reg;

    wsm_pkg::pixel_t center_rd_reg;
    wsm_pkg::pixel_t next_rd_reg;
    logic [wsm_pkg::VAL_W-1:0] up_rd_reg;
    logic            fwd_c_reg;
    logic            fwd_n_reg;
    wsm_pkg::pixel_t fwd_pixel_reg;
    logic [wsm_pkg::VAL_W-1:0] fwd_old_reg;

    wsm_pkg::pixel_t displaced_reg;
    wsm_pkg::pixel_t center;
    wsm_pkg::pixel_t next_px;
    logic [wsm_pkg::VAL_W-1:0] up_v;

    logic         op_valid_reg;
    wsm_pkg::op_t op_reg;
    wsm_pkg::op_t op_next;

    assign req_x_next = req_x + XW'(1);

    // reads at accept; the entry being written back this cycle is forwarded
    always_ff @(posedge aclk) begin
        if (req_valid) begin
            center_rd_reg <= prev_mem[req_x];
            next_rd_reg   <= prev_mem[req_x_next];
            up_rd_reg     <= older_mem[req_x];
            fwd_c_reg     <= s1_valid_reg && (s1_x_reg == req_x);
            fwd_n_reg     <= s1_valid_reg && (s1_x_reg == req_x_next);
            fwd_pixel_reg <= s1_pixel_reg;
            fwd_old_reg   <= center.v;
        end
        if (s1_valid_reg) begin
            prev_mem[s1_x_reg]  <= s1_pixel_reg;
            older_mem[s1_x_reg] <= center.v;
        end
    end

    always_ff @(posedge aclk) begin
        if (req_valid) begin
            s1_x_reg     <= req_x;
            s1_req_reg   <= req;
            s1_pixel_reg <= req_pixel;
        end
    end

    always_comb begin
        center  = fwd_c_reg ? fwd_pixel_reg : center_rd_reg;
        next_px = fwd_n_reg ? fwd_pixel_reg : next_rd_reg;
        up_v    = fwd_c_reg ? fwd_old_reg : up_rd_reg;
    end

    always_comb begin
        op_next.cv = center.v;
        op_next.wp = s1_req_reg.prev_ok ? center.sx : '0;
        op_next.pv = s1_req_reg.prev_ok ? displaced_reg.v : '0;
        op_next.wn = s1_req_reg.next_ok ? next_px.sx : '0;
        op_next.nv = s1_req_reg.next_ok ? next_px.v : '0;
        op_next.wu = s1_req_reg.up_ok ? center.sy : '0;
        op_next.uv = s1_req_reg.up_ok ? up_v : '0;
        // the pixel below is the incoming one; a flush carries zeros
        op_next.wd = s1_pixel_reg.sy;
        op_next.dv = s1_pixel_reg.v;
        op_next.diag = wsm_pkg::DIAG_W'(center.w) + wsm_pkg::DIAG_W'(center.sx)
                     + wsm_pkg::DIAG_W'(center.sy) + wsm_pkg::DIAG_W'(op_next.wn)
                     + wsm_pkg::DIAG_W'(op_next.wd);
        op_next.frame_end = s1_req_reg.frame_end;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            op_valid_reg  <= 1'b0;
            displaced_reg <= '0;
        end else begin
            s1_valid_reg <= req_valid;
            op_valid_reg <= s1_valid_reg && s1_req_reg.produce;
            if (s1_valid_reg) begin
                displaced_reg <= center;
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg <= op_next;
    end

    assign op_valid = op_valid_reg;
    assign op       = op_reg;

endmodule

`default_nettype wire

// ===== design/wsm_stencil_arith.sv =====
// stencil arithmetic: five parallel products, then a two-level signed sum
// three register stages; uses wsm_pkg types
`default_nettype none

module wsm_stencil_arith (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    op_valid,
    input  wsm_pkg::op_t op,
    output logic         res_valid,
    output wsm_pkg::res_t res
);

    logic signed [35:0] p0_reg;
    logic signed [32:0] p1_reg;
    logic signed [32:0] p2_reg;
    logic signed [32:0] p3_reg;
    logic signed [32:0] p4_reg;
    logic               v1_reg;
    logic               fe1_reg;

    logic signed [wsm_pkg::PROD_W-1:0] sa_reg;
    logic signed [wsm_pkg::PROD_W-1:0] sb_reg;
    logic signed [wsm_pkg::PROD_W-1:0] sa_next;
    logic signed [wsm_pkg::PROD_W-1:0] sb_next;
    logic               v2_reg;
    logic               fe2_reg;

    wsm_pkg::res_t      res_reg;
    logic               v3_reg;

    always_ff @(posedge aclk) begin
        p0_reg  <= $signed({1'b0, op.diag}) * $signed(op.cv);
        p1_reg  <= $signed({1'b0, op.wp}) * $signed(op.pv);
        p2_reg  <= $signed({1'b0, op.wn}) * $signed(op.nv);
        p3_reg  <= $signed({1'b0, op.wu}) * $signed(op.uv);
        p4_reg  <= $signed({1'b0, op.wd}) * $signed(op.dv);
        fe1_reg <= op.frame_end;
    end

    always_comb begin
        sa_next = wsm_pkg::PROD_W'(p0_reg) - wsm_pkg::PROD_W'(p1_reg)
                - wsm_pkg::PROD_W'(p2_reg);
        sb_next = wsm_pkg::PROD_W'(p3_reg) + wsm_pkg::PROD_W'(p4_reg);
    end

    always_ff @(posedge aclk) begin
        sa_reg  <= sa_next;
        sb_reg  <= sb_next;
        fe2_reg <= fe1_reg;
        res_reg.product   <= sa_reg - sb_reg;
        res_reg.frame_end <= fe2_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= op_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign res_valid = v3_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

// ===== design/wsm_out_fifo.sv =====
// small result queue between the arithmetic pipeline and the output port
// never overflows: the sequencer reserves a slot per result; uses wsm_pkg
`default_nettype none

module wsm_out_fifo (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     push,
    input  wsm_pkg::res_t push_data,
    input  wire logic     pop_ready,
    output logic          out_valid,
    output wsm_pkg::res_t out_data
);

    wsm_pkg::res_t q_mem [wsm_pkg::FIFO_DEPTH];

    logic [wsm_pkg::FIFO_AW-1:0]  wr_ptr_reg;
    logic [wsm_pkg::FIFO_AW-1:0]  rd_ptr_reg;
    logic [wsm_pkg::CREDIT_W-1:0] count_reg;
    logic [wsm_pkg::CREDIT_W-1:0] count_next;
    logic pop;

    assign out_valid = (count_reg != '0);
    assign out_data  = q_mem[rd_ptr_reg];
    assign pop       = out_valid && pop_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + wsm_pkg::CREDIT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - wsm_pkg::CREDIT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + wsm_pkg::FIFO_AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + wsm_pkg::FIFO_AW'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/weighted_stencil_matvec_top.sv =====
// five-point stencil product: one pixel per cycle while credits last, results lag one line
// results pass the line store, the arithmetic stages and the result queue to the master port
// throughput: 1 transaction per cycle given credit, set by the single read/write-back pass
// reset: position, line counter and credits cleared, registers back to clamped 1024;
// line memories keep their contents and need no clearing pass
// depends on wsm_pkg, wsm_line_store, wsm_stencil_arith, wsm_out_fifo
`default_nettype none

module weighted_stencil_matvec_top #(
    parameter int MAX_LINE_LENGTH = 1024,
    parameter int MAX_LINES       = 1024
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // pixel_value, data_weight, horiz_weight, vert_weight
    input  wire logic        s_tuser,   // command
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // product_value
    output logic             m_tlast,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_addr,
    input  wire logic [wsm_pkg::CFG_W-1:0] cfg_wdata
);

    localparam int XW    = $clog2(MAX_LINE_LENGTH);
    localparam int LEN_W = $clog2(MAX_LINE_LENGTH + 1);
    localparam int LN_W  = $clog2(MAX_LINES + 1);
    localparam int CLL_W = (LEN_W > wsm_pkg::CFG_W) ? LEN_W : wsm_pkg::CFG_W;
    localparam int CLN_W = (LN_W > wsm_pkg::CFG_W) ? LN_W : wsm_pkg::CFG_W;
    localparam int LEN_RST = (MAX_LINE_LENGTH < wsm_pkg::CFG_LEN_RESET)
                           ? MAX_LINE_LENGTH : wsm_pkg::CFG_LEN_RESET;
    localparam int CNT_RST = (MAX_LINES < wsm_pkg::CFG_CNT_RESET)
                           ? MAX_LINES : wsm_pkg::CFG_CNT_RESET;

    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    logic [LN_W-1:0]  cnt_reg;
    logic [LN_W-1:0]  cnt_next;
    logic [XW-1:0]    x_reg;
    logic [XW-1:0]    x_next;
    logic [LN_W-1:0]  ln_reg;
    logic [LN_W-1:0]  ln_next;
    logic [wsm_pkg::CREDIT_W-1:0] credit_reg;
    logic [wsm_pkg::CREDIT_W-1:0] credit_next;

    logic [CLL_W-1:0] wlen;
    logic [CLN_W-1:0] wcnt;
    logic [LEN_W-1:0] len_w;
    logic [LN_W-1:0]  cnt_w;

    logic accept;
    logic flush;
    logic last_in_line;
    logic ignore;
    logic act;
    logic take;
    logic pop;

    wsm_pkg::req_t   req;
    wsm_pkg::pixel_t req_pixel;

    logic         op_valid;
    wsm_pkg::op_t op;
    logic          res_valid;
    wsm_pkg::res_t res;
    wsm_pkg::res_t out_data;

    // clamp register writes into the usable range
    always_comb begin
        wlen = CLL_W'(cfg_wdata);
        wcnt = CLN_W'(cfg_wdata);
        if (wlen < CLL_W'(wsm_pkg::MIN_DIM)) begin
            len_w = LEN_W'(wsm_pkg::MIN_DIM);
        end else if (wlen > CLL_W'(MAX_LINE_LENGTH)) begin
            len_w = LEN_W'(MAX_LINE_LENGTH);
        end else begin
            len_w = LEN_W'(wlen);
        end
        if (wcnt < CLN_W'(wsm_pkg::MIN_DIM)) begin
            cnt_w = LN_W'(wsm_pkg::MIN_DIM);
        end else if (wcnt > CLN_W'(MAX_LINES)) begin
            cnt_w = LN_W'(MAX_LINES);
        end else begin
            cnt_w = LN_W'(wcnt);
        end
    end

    always_comb begin
        len_next = len_reg;
        cnt_next = cnt_reg;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                wsm_pkg::REG_LINE_LENGTH: len_next = len_w;
                wsm_pkg::REG_LINE_COUNT:  cnt_next = cnt_w;
                default:                  len_next = len_reg;
            endcase
        end
    end

    // sequencer: position and line counter advance at accept time
    assign s_tready     = (credit_reg < wsm_pkg::CREDIT_W'(wsm_pkg::FIFO_DEPTH));
    assign accept       = s_tvalid && s_tready;
    assign flush        = (s_tuser == wsm_pkg::CMD_FLUSH);
    assign last_in_line = ((LEN_W'(x_reg) + LEN_W'(1)) >= len_reg);
    assign ignore       = flush ? ((ln_reg < cnt_reg) || (ln_reg == '0)) : (ln_reg >= cnt_reg);
    assign act          = !ignore;
    assign take         = accept && act;

    always_comb begin
        req.produce   = (ln_reg != '0);
        req.prev_ok   = (x_reg != '0);
        req.next_ok   = !last_in_line;
        req.up_ok     = (ln_reg > LN_W'(1));
        req.frame_end = flush && last_in_line;
        req_pixel     = flush ? '0 : wsm_pkg::pixel_t'(s_tdata);
    end

    always_comb begin
        x_next  = x_reg;
        ln_next = ln_reg;
        if (take) begin
            if (last_in_line) begin
                x_next  = '0;
                ln_next = flush ? '0 : (ln_reg + LN_W'(1));
            end else begin
                x_next = x_reg + XW'(1);
            end
        end
    end

    // one credit per result in flight or queued
    assign pop = m_tvalid && m_tready;

    always_comb begin
        credit_next = credit_reg;
        if ((take && req.produce) && !pop) begin
            credit_next = credit_reg + wsm_pkg::CREDIT_W'(1);
        end else if (pop && !(take && req.produce)) begin
            credit_next = credit_reg - wsm_pkg::CREDIT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg    <= LEN_W'(LEN_RST);
            cnt_reg    <= LN_W'(CNT_RST);
            x_reg      <= '0;
            ln_reg     <= '0;
            credit_reg <= '0;
        end else begin
            len_reg    <= len_next;
            cnt_reg    <= cnt_next;
            x_reg      <= x_next;
            ln_reg     <= ln_next;
            credit_reg <= credit_next;
        end
    end

    wsm_line_store #(
        .DEPTH (MAX_LINE_LENGTH)
    ) u_line_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (take),
        .req_x     (x_reg),
        .req       (req),
        .req_pixel (req_pixel),
        .op_valid  (op_valid),
        .op        (op)
    );

    wsm_stencil_arith u_arith (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .op_valid  (op_valid),
        .op        (op),
        .res_valid (res_valid),
        .res       (res)
    );

    wsm_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_data (res),
        .pop_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (out_data)
    );

    assign m_tdata = out_data.product;
    assign m_tlast = out_data.frame_end;

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// self-checking bench for weighted_stencil_matvec_top: a line-order pixel stream in, stencil
// products out, compared against a bit-true predictor kept in a small scoreboard class
// depends on wsm_pkg and the design files under design/

class stencil_scoreboard;
    localparam int MAX_LEN = 1024;
    localparam int MAX_CNT = 1024;

    // predictor state, mirrors the block's line stores and counters
    logic [63:0]   line_mem   [MAX_LEN];
    logic [15:0]   older_vals [MAX_LEN];
    logic [63:0]   displaced;
    int unsigned   pos;
    int unsigned   line_no;
    logic [10:0]   len_reg;
    logic [10:0]   cnt_reg;

    logic [39:0]   product_q [$];
    bit            frame_end_q [$];
    int            errors;

    function new();
        foreach (line_mem[i]) begin
            line_mem[i] = '0;
            older_vals[i] = '0;
        end
        displaced = '0;
        pos = 0;
        line_no = 0;
        len_reg = 11'd1024;
        cnt_reg = 11'd1024;
        errors = 0;
    endfunction

    static function int unsigned clamp_dim(int unsigned v, int unsigned hi);
        if (v < 2) return 2;
        if (v > hi) return hi;
        return v;
    endfunction

    static function longint sval(logic [15:0] v);
        return longint'(signed'(v));
    endfunction

    function int unsigned eff_len();
        return clamp_dim(len_reg, MAX_LEN);
    endfunction

    function int unsigned eff_cnt();
        return clamp_dim(cnt_reg, MAX_CNT);
    endfunction

    function int outstanding();
        return product_q.size();
    endfunction

    function void write_reg(logic idx, logic [10:0] v);
        if (idx == wsm_pkg::REG_LINE_LENGTH) begin
            len_reg = v;
        end else begin
            cnt_reg = v;
        end
    endfunction

    // one accepted input transaction; queues the product it releases, if any
    function void note_input(logic cmd, logic [63:0] data);
        int unsigned len, cnt, x;
        bit          flush, last, has_next, has_down;
        logic [63:0] pix, center, nxt;
        longint      diag, acc, nsx, dsy, csx, csy;
        logic [39:0] prod;
        len = eff_len();
        cnt = eff_cnt();
        flush = (cmd == wsm_pkg::CMD_FLUSH);
        x = (pos >= MAX_LEN) ? MAX_LEN - 1 : pos;
        last = (x + 1 >= len);
        pix = '0;
        if (flush) begin
            if (line_no < cnt || line_no == 0) return;
        end else begin
            if (line_no >= cnt) return;
            pix = data;
        end
        center = line_mem[x];
        if (line_no >= 1) begin
            has_next = !last;
            has_down = !flush;
            nxt = has_next ? line_mem[x + 1] : '0;
            nsx = longint'(nxt[47:32]);
            dsy = longint'(pix[63:48]);
            csx = longint'(center[47:32]);
            csy = longint'(center[63:48]);
            // own sx and sy stay on the diagonal even at the first column or line
            diag = longint'(center[31:16]) + csx + csy;
            if (has_next) diag += nsx;
            if (has_down) diag += dsy;
            acc = diag * sval(center[15:0]);
            if (x > 0) acc -= csx * sval(displaced[15:0]);
            if (has_next) acc -= nsx * sval(nxt[15:0]);
            if (line_no > 1) acc -= csy * sval(older_vals[x]);
            if (has_down) acc -= dsy * sval(pix[15:0]);
            prod = acc[39:0];
            product_q = {product_q, prod};
            frame_end_q = {frame_end_q, flush && last};
        end
        older_vals[x] = center[15:0];
        displaced = center;
        line_mem[x] = pix;
        if (last) begin
            pos = 0;
            if (flush) line_no = 0;
            else line_no++;
        end else begin
            pos = x + 1;
        end
    endfunction

    function void check_result(logic [39:0] prod, logic last);
        logic [39:0] exp_prod;
        bit          exp_end;
        if (product_q.size() == 0) begin
            $error("product_value expected none actual %h", prod);
            errors++;
            return;
        end
        exp_prod = product_q.pop_front();
        exp_end = frame_end_q.pop_front();
        if (prod !== exp_prod) begin
            $error("product_value expected %h actual %h", exp_prod, prod);
            errors++;
        end
        if (last !== exp_end) begin
            $error("frame_end expected %0d actual %0d", exp_end, last);
            errors++;
        end
    endfunction
endclass

module tb;

    localparam int QUIET_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 20;
    localparam int RANDOM_ITEMS  = 680;
    localparam int CALM_ITEMS    = 200;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [63:0]       s_tdata = '0;
    logic              s_tuser = wsm_pkg::CMD_PIXEL;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [39:0]       m_tdata;
    logic              m_tlast;
    logic              cfg_wr_en = 1'b0;
    logic              cfg_addr = wsm_pkg::REG_LINE_LENGTH;
    logic [wsm_pkg::CFG_W-1:0] cfg_wdata = '0;

    stencil_scoreboard sb = new();

    logic        stim_cmd_q [$];
    logic [63:0] stim_data_q [$];
    bit          idle_on = 1'b1;
    int          good_items = 0;
    int          quiet = 0;
    int          stall_left = 0;

    weighted_stencil_matvec_top #(
        .MAX_LINE_LENGTH(1024),
        .MAX_LINES      (1024)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // receiver: random stall bursts while idling is on
    initial begin
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                stall_left--;
                m_tready = 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 6) - 1;
                m_tready = 1'b0;
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet = 0;
        end else begin
            quiet++;
        end
        if (quiet >= QUIET_LIMIT) begin
            $display("weighted_stencil_matvec_top regression: fail");
            $finish;
        end
    end

    function automatic logic [63:0] mk(logic [15:0] v, logic [15:0] w, logic [15:0] sx,
                                       logic [15:0] sy);
        return {sy, sx, w, v};
    endfunction

    // random pixel, with corner values mixed in per field
    function automatic logic [63:0] rand_pixel();
        logic [63:0] d;
        int          k;
        d = {$urandom, $urandom};
        for (k = 0; k < 4; k++) begin
            case ($urandom_range(0, 11))
                0: d[k*16 +: 16] = 16'h0000;
                1: d[k*16 +: 16] = 16'hFFFF;
                2: d[k*16 +: 16] = 16'h8000;
                3: d[k*16 +: 16] = 16'h7FFF;
                4: d[k*16 +: 16] = 16'h1000;
                default: ;
            endcase
        end
        return d;
    endfunction

    task automatic add_item(logic cmd, logic [63:0] data);
        stim_cmd_q = {stim_cmd_q, cmd};
        stim_data_q = {stim_data_q, data};
    endtask

    // sends everything queued; called and returns at a falling edge
    task automatic drive_queue();
        int gap;
        while (stim_cmd_q.size() != 0) begin
            if (idle_on && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 6);
                s_tvalid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            s_tvalid = 1'b1;
            s_tuser = stim_cmd_q.pop_front();
            s_tdata = stim_data_q.pop_front();
            do begin
                @(posedge aclk);
            end while (!s_tready);
            sb.note_input(s_tuser, s_tdata);
            @(negedge aclk);
        end
        s_tvalid = 1'b0;
        @(negedge aclk);
    endtask

    // sender holds off until every predicted product is out, then lets the pipeline settle
    task automatic wait_drain();
        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_regs(int unsigned len_val, int unsigned cnt_val);
        cfg_wr_en = 1'b1;
        cfg_addr = wsm_pkg::REG_LINE_LENGTH;
        cfg_wdata = len_val[wsm_pkg::CFG_W-1:0];
        @(negedge aclk);
        cfg_addr = wsm_pkg::REG_LINE_COUNT;
        cfg_wdata = cnt_val[wsm_pkg::CFG_W-1:0];
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        sb.write_reg(wsm_pkg::REG_LINE_LENGTH, len_val[wsm_pkg::CFG_W-1:0]);
        sb.write_reg(wsm_pkg::REG_LINE_COUNT, cnt_val[wsm_pkg::CFG_W-1:0]);
    endtask

    // one whole frame plus its flush line; noisy adds transactions the block must ignore
    task automatic run_frame(bit noisy, bit may_pause);
        int unsigned len, cnt;
        int          x, y;
        len = sb.eff_len();
        cnt = sb.eff_cnt();
        for (y = 0; y < cnt; y++) begin
            for (x = 0; x < len; x++) begin
                if (noisy && $urandom_range(0, 30) == 0) begin
                    add_item(wsm_pkg::CMD_FLUSH, rand_pixel());
                end
                add_item(wsm_pkg::CMD_PIXEL, rand_pixel());
                good_items++;
            end
            if (may_pause && $urandom_range(0, 9) == 0) begin
                drive_queue();
                wait_drain();
            end
        end
        if (noisy && $urandom_range(0, 2) == 0) add_item(wsm_pkg::CMD_PIXEL, rand_pixel());
        for (x = 0; x < len; x++) begin
            add_item(wsm_pkg::CMD_FLUSH, rand_pixel());
            good_items++;
        end
        if (noisy && $urandom_range(0, 3) == 0) add_item(wsm_pkg::CMD_FLUSH, rand_pixel());
        drive_queue();
    endtask

    initial begin
        int unsigned len_val, cnt_val;
        int          i, r;

        repeat (10) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // smallest frame, out-of-range writes clamp up to 2x2, full-scale operands
        write_regs(0, 1);
        add_item(wsm_pkg::CMD_FLUSH, '0);
        add_item(wsm_pkg::CMD_PIXEL, mk(16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        add_item(wsm_pkg::CMD_PIXEL, mk(16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        add_item(wsm_pkg::CMD_FLUSH, '1);
        add_item(wsm_pkg::CMD_PIXEL, mk(16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        add_item(wsm_pkg::CMD_PIXEL, mk(16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        add_item(wsm_pkg::CMD_PIXEL, mk(16'h1234, 16'h0000, 16'h0000, 16'h0000));
        add_item(wsm_pkg::CMD_FLUSH, '0);
        add_item(wsm_pkg::CMD_FLUSH, '0);
        add_item(wsm_pkg::CMD_FLUSH, '0);
        drive_queue();
        wait_drain();

        // 3x3 with zero and full weights against extreme values
        write_regs(3, 3);
        for (i = 0; i < 9; i++) begin
            add_item(wsm_pkg::CMD_PIXEL, mk((i % 2) ? 16'h8000 : 16'h7FFF,
                                            (i % 3 == 0) ? 16'h0000 : 16'hFFFF,
                                            (i % 4 == 1) ? 16'h0000 : 16'hFFFF,
                                            (i % 3 == 2) ? 16'h0000 : 16'hFFFF));
        end
        for (i = 0; i < 3; i++) add_item(wsm_pkg::CMD_FLUSH, '0);
        drive_queue();
        wait_drain();

        // line length shrinks during line 0: the position past the new length ends the line
        write_regs(8, 3);
        for (i = 0; i < 5; i++) add_item(wsm_pkg::CMD_PIXEL, rand_pixel());
        drive_queue();
        wait_drain();
        write_regs(3, 3);
        for (i = 0; i < 7; i++) add_item(wsm_pkg::CMD_PIXEL, rand_pixel());
        for (i = 0; i < 3; i++) add_item(wsm_pkg::CMD_FLUSH, rand_pixel());
        drive_queue();
        wait_drain();

        // line count shrinks below the lines already received, so flushing opens early
        write_regs(4, 6);
        for (i = 0; i < 12; i++) add_item(wsm_pkg::CMD_PIXEL, rand_pixel());
        drive_queue();
        wait_drain();
        write_regs(4, 2);
        for (i = 0; i < 4; i++) add_item(wsm_pkg::CMD_FLUSH, rand_pixel());
        drive_queue();
        wait_drain();

        // a wide frame and a tall one
        write_regs(256, 0);
        run_frame(1'b0, 1'b0);
        wait_drain();
        write_regs(1, 200);
        run_frame(1'b0, 1'b0);
        wait_drain();

        good_items = 0;
        while (good_items < RANDOM_ITEMS) begin
            if (good_items > RANDOM_ITEMS - CALM_ITEMS) idle_on = 1'b0;
            if ($urandom_range(0, 1) == 0) begin
                wait_drain();
                r = $urandom_range(0, 9);
                if (r == 0) len_val = $urandom_range(9, 40);
                else if (r == 1) len_val = $urandom_range(0, 1);
                else len_val = $urandom_range(2, 8);
                r = $urandom_range(0, 9);
                if (r == 0) cnt_val = $urandom_range(7, 16);
                else if (r == 1) cnt_val = $urandom_range(0, 1);
                else cnt_val = $urandom_range(2, 6);
                write_regs(len_val, cnt_val);
            end
            run_frame(1'b1, 1'b1);
        end

        wait_drain();
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("weighted_stencil_matvec_top regression: pass");
        end else begin
            $display("weighted_stencil_matvec_top regression: fail");
        end
        $finish;
    end
endmodule
